// File: rtl/core/cfq_pkg.sv
// shared types, constants and helpers for the circular fifo queue
package cfq_pkg;

   localparam int DEPTH          = 128;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int CNT_W          = 8;
   localparam int CAP_W          = 8;
   localparam int DATA_W         = 32;
   localparam int MIN_CAPACITY   = 5;
   localparam int CAPACITY_RESET = 128;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_CLR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   // capacity register saturated to the usable range
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] c;
      c = CNT_W'(cap);
      if (c < CNT_W'(MIN_CAPACITY))
         c = CNT_W'(MIN_CAPACITY);
      if (c > CNT_W'(DEPTH))
         c = CNT_W'(DEPTH);
      return c;
   endfunction

   // ring index step with wrap at the effective capacity
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
      logic [IDX_W:0] n;
      n = {1'b0, idx} + (IDX_W+1)'(1);
      if (n >= (IDX_W+1)'(cap))
         return '0;
      return n[IDX_W-1:0];
   endfunction

endpackage

// File: rtl/core/cfq_intf.sv
// channel interfaces of the circular fifo queue
interface cfq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic signed [cfq_pkg::DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface cfq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic signed [cfq_pkg::DATA_W-1:0] dequeued;
   logic signed [cfq_pkg::DATA_W-1:0] front_value;
   logic signed [cfq_pkg::DATA_W-1:0] rear_value;
   logic [cfq_pkg::CNT_W-1:0]         count;
   logic                              is_empty;
   logic                              is_full;

   modport source (output valid, output status, output dequeued, output front_value,
                   output rear_value, output count, output is_empty, output is_full,
                   input ready);
   modport sink   (input valid, input status, input dequeued, input front_value,
                   input rear_value, input count, input is_empty, input is_full,
                   output ready);
endinterface

interface cfq_csr_if;
   logic                      valid;
   logic                      ready;
   logic [cfq_pkg::CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/circular_fifo_queue_unit.sv
// circular fifo queue: ring storage in a synchronous memory, cached front and rear words
// responses are registered; a dequeue that leaves entries behind first passes the fetch state
//   (the new front word is read from the storage memory)
// throughput: one request per cycle while the response is taken, none in the fetch state
// reset: synchronous; queue empty, capacity 128; storage contents stay undefined
// capacity writes are always accepted and empty the queue
module circular_fifo_queue_unit (
   input  logic             clock,
   input  logic             reset,
   cfq_req_if.sink          req_bus,
   cfq_rsp_if.source        rsp_bus,
   cfq_csr_if.sink          csr_bus
);
   import cfq_pkg::*;

   logic signed [DATA_W-1:0] storage_ff [DEPTH];
   logic signed [DATA_W-1:0] mem_rd_data_ff;

   state_type            state_ff, state_in;
   logic [CAP_W-1:0]     cap_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] rear_ff, rear_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff, status_in;
   logic signed [DATA_W-1:0] rsp_dequeued_ff, dq_in;
   logic signed [DATA_W-1:0] rsp_front_ff;
   logic signed [DATA_W-1:0] rsp_rear_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_full_ff;

   logic [CNT_W-1:0]     cap_eff;
   logic                 accept;
   logic                 req_ready;
   logic                 fetch_done;
   logic                 wr_en;
   logic                 need_fetch;
   logic                 csr_write;

   assign cap_eff   = eff_cap(cap_ff);
   assign accept    = req_bus.valid && req_ready;
   assign csr_write = csr_bus.valid && csr_bus.ready;

   // one request step on the cached state
   always_comb begin
      status_in  = STS_OK;
      dq_in      = '0;
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      front_in   = front_ff;
      rear_in    = rear_ff;
      wr_en      = 1'b0;
      need_fetch = 1'b0;
      case (req_bus.op)
         OP_ENQ: begin
            if (count_ff >= cap_eff) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               tail_in  = advance(tail_ff, cap_eff);
               wr_en    = 1'b1;
               rear_in  = req_bus.value;
               if (count_ff == '0)
                  front_in = req_bus.value;
            end
         end
         OP_DEQ: begin
            if (count_ff == '0) begin
               status_in = STS_EMPTY;
            end else begin
               dq_in    = front_ff;
               count_in = count_ff - CNT_W'(1);
               head_in  = advance(head_ff, cap_eff);
               // new front lives only in storage
               if (count_ff > CNT_W'(1))
                  need_fetch = 1'b1;
            end
         end
         OP_CLR: begin
            count_in = '0;
            head_in  = IDX_W'(1);
            tail_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && need_fetch)
               state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = 1'b0;
      fetch_done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_bus.ready;
         end
         S_FETCH: begin
            fetch_done = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // storage memory, registered read
   always_ff @(posedge clock) begin
      if (accept && wr_en)
         storage_ff[tail_in] <= req_bus.value;
      if (accept && need_fetch)
         mem_rd_data_ff <= storage_ff[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_W'(CAPACITY_RESET);
         count_ff     <= '0;
         head_ff      <= IDX_W'(1);
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            cap_ff   <= csr_bus.data;
            count_ff <= '0;
            head_ff  <= IDX_W'(1);
            tail_ff  <= '0;
         end else if (accept) begin
            count_ff <= count_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
         end
         if (accept)
            rsp_valid_ff <= !need_fetch;
         else if (fetch_done)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff        <= front_in;
         rear_ff         <= rear_in;
         rsp_status_ff   <= status_in;
         rsp_dequeued_ff <= dq_in;
         rsp_front_ff    <= (count_in != '0) ? front_in : '0;
         rsp_rear_ff     <= (count_in != '0) ? rear_in : '0;
         rsp_count_ff    <= count_in;
         rsp_empty_ff    <= (count_in == '0);
         rsp_full_ff     <= (count_in == cap_eff);
      end else if (fetch_done) begin
         front_ff     <= mem_rd_data_ff;
         rsp_front_ff <= mem_rd_data_ff;
      end
   end

   assign req_bus.ready       = req_ready;
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.dequeued    = rsp_dequeued_ff;
   assign rsp_bus.front_value = rsp_front_ff;
   assign rsp_bus.rear_value  = rsp_rear_ff;
   assign rsp_bus.count       = rsp_count_ff;
   assign rsp_bus.is_empty    = rsp_empty_ff;
   assign rsp_bus.is_full     = rsp_full_ff;

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("fill count beyond effective capacity");

   a_fetch_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> !rsp_valid_ff)
      else $error("response register busy during front fetch");

   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && need_fetch && !csr_write) |=> (state_ff == S_FETCH && !req_ready))
      else $error("front fetch not started after dequeue");

   a_fetch_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("fetched front word not presented");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.op == OP_CLR) |=> (count_ff == '0 && head_ff == IDX_W'(1)))
      else $error("clear left entries behind");
`endif

endmodule
